>>> rtl/plhi_pkg.sv
// plhi_pkg: shared codes and fixed field widths for the polyline height interpolator
// no dependencies; used by the top level
package plhi_pkg;

  // input word kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // fixed widths of the index, segment and register fields
  localparam int IDX_BITS = 6;
  localparam int SEG_BITS = 6;
  localparam int CFG_BITS = 7;

  // breakpoint count after reset
  localparam logic [CFG_BITS-1:0] NUM_POINTS_RST = 7'd2;

endpackage

>>> rtl/plhi_ram.sv
// plhi_ram: generic single write port, single read port RAM with registered read
// no dependencies
module plhi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/plhi_div.sv
// plhi_div: restoring unsigned divider, one quotient bit per cycle
// no dependencies; the dividend must satisfy num < den * 2**QUO_W
module plhi_div #(
  parameter int DEN_W = 12,
  parameter int QUO_W = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic                   done,
  output logic [QUO_W-1:0]       quo
);

  localparam int CW = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] work_r, work_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             take;

  // one shift-subtract step
  assign trial = {rem_r, work_r[QUO_W-1]};
  assign take  = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    work_nxt = work_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num[DEN_W+QUO_W-1:QUO_W];
      work_nxt = num[QUO_W-1:0];
      den_nxt  = den;
      cnt_nxt  = CW'(QUO_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rem_nxt  = take ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      work_nxt = {work_r[QUO_W-2:0], take};
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state resets, datapath does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
    den_r  <= den_nxt;
  end

  assign done = done_r;
  assign quo  = work_r;

endmodule

>>> rtl/polyline_height_interpolator.sv
// polyline_height_interpolator: breakpoint table, segment scan and interpolation
// depends on plhi_pkg, plhi_ram, plhi_div
//
//   channel  | ports                                      | flow
//   ---------+--------------------------------------------+-----------------------------
//   input    | start, busy, in_kind, in_point_*, in_query_x | word taken on start & !busy
//   result   | out_valid, out_height, out_found, out_segment| one cycle strobe, no stall
//   config   | cfg_we, cfg_wdata                          | written when cfg_we is high
//
// a load word gives no result; busy stays low
// a query reads breakpoint 0, then tests one segment per cycle through the table
// RAM read port; a hit multiplies once and runs the divider for COORD_BITS+4
// steps, then gives a found result; a miss gives a not-found result after the last
// segment; fewer than two points answers in the cycle after the word is taken,
// with busy staying low
// synchronous active-low reset sets num_points to 2; table contents are not cleared
module polyline_height_interpolator #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_kind,
  input  logic [plhi_pkg::IDX_BITS-1:0]     in_point_index,
  input  logic [COORD_BITS-1:0]             in_point_x,
  input  logic [COORD_BITS-1:0]             in_point_y,
  input  logic [COORD_BITS+3:0]             in_query_x,
  output logic                              out_valid,
  output logic [COORD_BITS+3:0]             out_height,
  output logic                              out_found,
  output logic [plhi_pkg::SEG_BITS-1:0]     out_segment,
  input  logic                              cfg_we,
  input  logic [plhi_pkg::CFG_BITS-1:0]     cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int QW = COORD_BITS + 4;
  localparam int PW = 2 * COORD_BITS + 4;
  localparam int HW = COORD_BITS + 6;
  localparam int SW = plhi_pkg::SEG_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIRST  = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [plhi_pkg::CFG_BITS-1:0] num_points_r, num_points_nxt;
  logic [NW-1:0]                 n_r, n_nxt;
  logic [AW-1:0]                 i_r, i_nxt;
  logic [QW-1:0]                 q_r, q_nxt;
  logic [COORD_BITS-1:0]         prev_x_r, prev_x_nxt;
  logic [COORD_BITS-1:0]         prev_y_r, prev_y_nxt;
  logic [QW-1:0]                 dxq_r, dxq_nxt;
  logic [COORD_BITS-1:0]         dy_r, dy_nxt;
  logic                          neg_r, neg_nxt;
  logic [COORD_BITS-1:0]         den_r, den_nxt;
  logic [PW-1:0]                 prod_r, prod_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [QW-1:0]                 out_height_r, out_height_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [plhi_pkg::SEG_BITS-1:0] out_segment_r, out_segment_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [2*COORD_BITS-1:0]       ram_rdata;
  logic [COORD_BITS-1:0]         cur_x;
  logic [COORD_BITS-1:0]         cur_y;
  logic [QW-1:0]                 lo;
  logic [QW-1:0]                 hi;
  logic                          hit;
  logic                          more;
  logic                          accept;
  logic [NW-1:0]                 n_clamp;
  logic                          div_start;
  logic                          div_done;
  logic [QW-1:0]                 div_quo;
  logic signed [HW-1:0]          h_sum;

  assign accept = start && (state_r == S_IDLE);

  // breakpoint table, x in the upper half
  assign ram_we    = accept && (in_kind == plhi_pkg::KIND_LOAD)
                     && (int'(in_point_index) < MAX_POINTS);
  assign ram_waddr = AW'(in_point_index);

  always_comb begin
    case (state_r)
      S_IDLE:  ram_raddr = '0;
      S_CMP:   ram_raddr = i_r + AW'(2);
      default: ram_raddr = i_r + AW'(1);
    endcase
  end

  plhi_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_point_x, in_point_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_x = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign cur_y = ram_rdata[COORD_BITS-1:0];

  // segment test against the scaled breakpoints
  assign lo   = {prev_x_r, 4'b0000};
  assign hi   = {cur_x, 4'b0000};
  assign hit  = (lo <= q_r) && (q_r < hi);
  assign more = ((NW + 1)'(i_r) + (NW + 1)'(2)) < (NW + 1)'(n_r);

  // breakpoint count limited to the table depth
  assign n_clamp = (int'(num_points_r) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(num_points_r);

  // divider for the slope term
  assign div_start = (state_r == S_DSTART);

  plhi_div #(
    .DEN_W (COORD_BITS),
    .QUO_W (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // base height plus or minus the quotient
  assign h_sum = neg_r ? ($signed({2'b00, prev_y_r, 4'b0000}) - $signed({2'b00, div_quo}))
                       : ($signed({2'b00, prev_y_r, 4'b0000}) + $signed({2'b00, div_quo}));

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    num_points_nxt  = num_points_r;
    n_nxt           = n_r;
    i_nxt           = i_r;
    q_nxt           = q_r;
    prev_x_nxt      = prev_x_r;
    prev_y_nxt      = prev_y_r;
    dxq_nxt         = dxq_r;
    dy_nxt          = dy_r;
    neg_nxt         = neg_r;
    den_nxt         = den_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = 1'b0;
    out_height_nxt  = out_height_r;
    out_found_nxt   = out_found_r;
    out_segment_nxt = out_segment_r;

    if (cfg_we) begin
      num_points_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == plhi_pkg::KIND_QUERY)) begin
          q_nxt = in_query_x;
          n_nxt = n_clamp;
          i_nxt = '0;
          if (n_clamp < NW'(2)) begin
            out_valid_nxt   = 1'b1;
            out_height_nxt  = '0;
            out_found_nxt   = 1'b0;
            out_segment_nxt = '0;
          end else begin
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        prev_x_nxt = cur_x;
        prev_y_nxt = cur_y;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          dxq_nxt   = q_r - lo;
          neg_nxt   = (cur_y < prev_y_r);
          dy_nxt    = (cur_y < prev_y_r) ? (prev_y_r - cur_y) : (cur_y - prev_y_r);
          den_nxt   = cur_x - prev_x_r;
          state_nxt = S_MUL;
        end else if (more) begin
          prev_x_nxt = cur_x;
          prev_y_nxt = cur_y;
          i_nxt      = i_r + AW'(1);
        end else begin
          out_valid_nxt   = 1'b1;
          out_height_nxt  = '0;
          out_found_nxt   = 1'b0;
          out_segment_nxt = '0;
          state_nxt       = S_IDLE;
        end
      end
      S_MUL: begin
        prod_nxt  = PW'(dxq_r) * PW'(dy_r);
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          out_valid_nxt   = 1'b1;
          out_height_nxt  = h_sum[HW-1] ? '0 : h_sum[QW-1:0];
          out_found_nxt   = 1'b1;
          out_segment_nxt = SW'(i_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers reset, datapath registers do not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_points_r <= plhi_pkg::NUM_POINTS_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      num_points_r <= num_points_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    n_r           <= n_nxt;
    i_r           <= i_nxt;
    q_r           <= q_nxt;
    prev_x_r      <= prev_x_nxt;
    prev_y_r      <= prev_y_nxt;
    dxq_r         <= dxq_nxt;
    dy_r          <= dy_nxt;
    neg_r         <= neg_nxt;
    den_r         <= den_nxt;
    prod_r        <= prod_nxt;
    out_height_r  <= out_height_nxt;
    out_found_r   <= out_found_nxt;
    out_segment_r <= out_segment_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_height  = out_height_r;
  assign out_found   = out_found_r;
  assign out_segment = out_segment_r;

endmodule

>>> dv/tb_polyline_height_interpolator.sv
`timescale 1ns / 1ps
// tb_polyline_height_interpolator: self-checking bench for the polyline height interpolator
// depends on plhi_pkg and polyline_height_interpolator; directed table, then random phases

module tb_polyline_height_interpolator;

  localparam logic KIND_LOAD = plhi_pkg::KIND_LOAD;
  localparam logic KIND_QUERY = plhi_pkg::KIND_QUERY;
  localparam int IDX_BITS = plhi_pkg::IDX_BITS;
  localparam int SEG_BITS = plhi_pkg::SEG_BITS;
  localparam int CFG_BITS = plhi_pkg::CFG_BITS;
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 12;
  localparam int HW = COORD_BITS + 4;
  localparam int SETTLE_CYCLES = 120;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 58;
  localparam int NUM_PHASES = 12;
  localparam int MAX_REPORTS = 100;
  localparam int FIFO_DEPTH = 16;
  localparam logic [7:0] NO_CFG = 8'hFF;

  typedef struct packed {
    logic [HW-1:0]       height;
    logic                found;
    logic [SEG_BITS-1:0] segment;
  } height_t;

  typedef struct packed {
    logic [HW-1:0] qx;
    height_t       res;
  } pending_t;

  // one directed word; set_n other than NO_CFG rewrites num_points first
  typedef struct packed {
    logic                  kind;
    logic [IDX_BITS-1:0]   idx;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [HW-1:0]         qx;
    logic                  fixed_want;
    height_t               want;
    logic [7:0]            set_n;
  } row_t;

  localparam height_t NOT_FOUND = '0;
  localparam int NUM_ROWS = 25;

  // directed words: extremes, truncation, degenerate segments, few points
  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    '{KIND_LOAD,  6'd0,  12'd0,    12'd0,    16'd0,     1'b0, NOT_FOUND, NO_CFG},
    '{KIND_LOAD,  6'd1,  12'd4095, 12'd4095, 16'd0,     1'b0, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd0,     1'b1, '{16'd0, 1'b1, 6'd0}, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd65519, 1'b1, '{16'd65519, 1'b1, 6'd0}, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd65520, 1'b1, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd65535, 1'b1, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd63, 12'd4095, 12'd4095, 16'd32768, 1'b0, NOT_FOUND, NO_CFG},
    '{KIND_LOAD,  6'd0,  12'd100,  12'd4095, 16'd65535, 1'b0, NOT_FOUND, NO_CFG},
    '{KIND_LOAD,  6'd1,  12'd200,  12'd0,    16'd65535, 1'b0, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd1600,  1'b1, '{16'd65520, 1'b1, 6'd0}, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd1599,  1'b1, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd3199,  1'b0, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd3200,  1'b1, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd2401,  1'b0, NOT_FOUND, NO_CFG},
    '{KIND_LOAD,  6'd1,  12'd100,  12'd7,    16'd0,     1'b0, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd1600,  1'b1, NOT_FOUND, NO_CFG},
    '{KIND_LOAD,  6'd1,  12'd50,   12'd7,    16'd0,     1'b0, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd1600,  1'b1, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd0,     1'b1, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd0,     1'b1, NOT_FOUND, 8'd1},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd65535, 1'b1, NOT_FOUND, 8'd0},
    '{KIND_LOAD,  6'd1,  12'd4095, 12'd0,    16'd0,     1'b0, NOT_FOUND, 8'd2},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd1600,  1'b0, NOT_FOUND, NO_CFG},
    '{KIND_QUERY, 6'd0,  12'd0,    12'd0,    16'd65519, 1'b0, NOT_FOUND, NO_CFG},
    '{KIND_LOAD,  6'd63, 12'd4095, 12'd4095, 16'd0,     1'b0, NOT_FOUND, NO_CFG}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = KIND_LOAD;
  logic [IDX_BITS-1:0] in_point_index = '0;
  logic [COORD_BITS-1:0] in_point_x = '0;
  logic [COORD_BITS-1:0] in_point_y = '0;
  logic [HW-1:0] in_query_x = '0;
  logic out_valid;
  logic [HW-1:0] out_height;
  logic out_found;
  logic [SEG_BITS-1:0] out_segment;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  // bench copy of the breakpoint table and the count register
  logic [COORD_BITS-1:0] bp_x [MAX_POINTS];
  logic [COORD_BITS-1:0] bp_y [MAX_POINTS];
  logic [CFG_BITS-1:0] points_in_use = plhi_pkg::NUM_POINTS_RST;

  // expected results in order, written by the sender, read by the checker
  pending_t pend_fifo [FIFO_DEPTH];
  int pend_wr = 0;
  int pend_rd = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;

  always #4 clk = ~clk;

  polyline_height_interpolator #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_point_index(in_point_index),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_query_x(in_query_x),
    .out_valid(out_valid),
    .out_height(out_height),
    .out_found(out_found),
    .out_segment(out_segment),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // first segment holding q, then 16*y_i + dx*dy/dx_seg truncated toward zero, clamped at zero
  function automatic height_t interpolate_height(input logic [HW-1:0] q);
    height_t r;
    int n;
    longint lo, hi, dxq, dy, den, h;
    r = NOT_FOUND;
    n = (points_in_use > MAX_POINTS) ? MAX_POINTS : points_in_use;
    for (int i = 0; i + 1 < n && !r.found; i++) begin
      lo = longint'(bp_x[i]) << 4;
      hi = longint'(bp_x[i+1]) << 4;
      if (lo <= q && q < hi) begin
        dxq = q - lo;
        dy = longint'(bp_y[i+1]) - longint'(bp_y[i]);
        den = longint'(bp_x[i+1]) - longint'(bp_x[i]);
        h = (longint'(bp_y[i]) << 4) + (dxq * dy) / den;
        if (h < 0) h = 0;
        r.height = h[HW-1:0];
        r.found = 1'b1;
        r.segment = i[SEG_BITS-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [HW-1:0] qx,
                                 input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0s: query %0d got %0d expected %0d", what, qx, got, want);
  endtask

  // present one word, hold it until taken, then update the bench table or queue
  task automatic send_word(input logic kind, input logic [IDX_BITS-1:0] idx,
                           input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                           input logic [HW-1:0] qx, input logic fixed_want,
                           input height_t want);
    pending_t entry;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_point_index <= idx;
    in_point_x <= px;
    in_point_y <= py;
    in_query_x <= qx;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind == KIND_LOAD) begin
      bp_x[idx] = px;
      bp_y[idx] = py;
    end else begin
      entry.qx = qx;
      entry.res = fixed_want ? want : interpolate_height(qx);
      pend_fifo[pend_wr % FIFO_DEPTH] = entry;
      pend_wr++;
    end
  endtask

  // register write once every query has answered and the block has settled
  task automatic set_points(input logic [CFG_BITS-1:0] n);
    start <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    points_in_use = n;
  endtask

  // result checker against the oldest pending word
  always @(posedge clk) begin
    pending_t exp_word;
    if (rst_n && out_valid) begin
      if (pend_wr == pend_rd) begin
        report_mismatch("result with nothing pending", '0, 32'(out_height), 32'd0);
      end else begin
        exp_word = pend_fifo[pend_rd % FIFO_DEPTH];
        pend_rd++;
        if (out_height !== exp_word.res.height)
          report_mismatch("height", exp_word.qx, 32'(out_height), 32'(exp_word.res.height));
        if (out_found !== exp_word.res.found)
          report_mismatch("found", exp_word.qx, 32'(out_found), 32'(exp_word.res.found));
        if (out_segment !== exp_word.res.segment)
          report_mismatch("segment", exp_word.qx, 32'(out_segment),
                          32'(exp_word.res.segment));
      end
    end
  end

  // cycles with neither a word taken nor a result out
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL polyline_height_interpolator");
    $finish;
  end

  initial begin
    int phase_points [NUM_PHASES];
    int idle_by_phase [3];
    int n_eff, x, y, step, sel, seg, lo, hi, q;
    phase_points = '{64, 2, 127, 1, 65, 0, 3, 64, -1, -1, -1, -1};
    idle_by_phase = '{0, 73, 28};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIR_ROWS[r].set_n != NO_CFG) set_points(DIR_ROWS[r].set_n[CFG_BITS-1:0]);
      send_word(DIR_ROWS[r].kind, DIR_ROWS[r].idx, DIR_ROWS[r].px, DIR_ROWS[r].py,
                DIR_ROWS[r].qx, DIR_ROWS[r].fixed_want, DIR_ROWS[r].want);
    end

    // random phases: new count, fresh polyline, then queries with some stray loads
    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct = 0;
      set_points(CFG_BITS'((phase_points[p] < 0) ? $urandom_range(2, MAX_POINTS)
                                                 : phase_points[p]));
      sender_idle_pct = idle_by_phase[p % 3];
      n_eff = (points_in_use > MAX_POINTS) ? MAX_POINTS : points_in_use;

      // mostly rising x; now and then a repeated or falling breakpoint
      x = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
      for (int k = 0; k < n_eff; k++) begin
        if (k > 0) begin
          step = (4095 - x) / (n_eff - k);
          if ($urandom_range(0, 11) == 0) x = $urandom_range(0, x);
          else x = x + $urandom_range(1, 2 * step + 1);
          if (x > 4095) x = 4095;
        end
        sel = $urandom_range(0, 7);
        y = (sel == 0) ? 0 : (sel == 1) ? 4095 : $urandom_range(0, 4095);
        send_word(KIND_LOAD, IDX_BITS'(k), COORD_BITS'(x), COORD_BITS'(y),
                  HW'($urandom_range(0, 65535)), 1'b0, NOT_FOUND);
      end

      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          send_word(KIND_LOAD, IDX_BITS'($urandom_range(0, MAX_POINTS - 1)),
                    COORD_BITS'($urandom_range(0, 4095)), COORD_BITS'($urandom_range(0, 4095)),
                    HW'($urandom_range(0, 65535)), 1'b0, NOT_FOUND);
        end else begin
          sel = $urandom_range(0, 99);
          seg = (n_eff >= 2) ? $urandom_range(0, n_eff - 2) : 0;
          lo = int'(bp_x[seg]) * 16;
          hi = int'(bp_x[seg+1]) * 16;
          if (n_eff >= 2 && sel < 55 && hi > lo) q = $urandom_range(lo, hi - 1);
          else if (n_eff >= 2 && sel < 70) q = ($urandom_range(0, 1) || lo == 0) ? lo : lo - 1;
          else if (sel < 88) q = $urandom_range(0, 65535);
          else begin
            case ($urandom_range(0, 3))
              0: q = 0;
              1: q = 65535;
              2: q = 65520;
              default: q = 65519;
            endcase
          end
          send_word(KIND_QUERY, IDX_BITS'($urandom_range(0, MAX_POINTS - 1)),
                    COORD_BITS'($urandom_range(0, 4095)), COORD_BITS'($urandom_range(0, 4095)),
                    HW'(q), 1'b0, NOT_FOUND);
        end
      end
    end

    // drain and settle
    start <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS polyline_height_interpolator");
    else $display("FAIL polyline_height_interpolator");
    $finish;
  end

endmodule

>>> sim.f
rtl/plhi_pkg.sv
rtl/plhi_ram.sv
rtl/plhi_div.sv
rtl/polyline_height_interpolator.sv
dv/tb_polyline_height_interpolator.sv
